[rtl/core/byte_ring_fifo_overwrite_top_defines.svh]
// Assertion macros shared by the byte ring FIFO checker.
`ifndef BYTE_RING_FIFO_OVERWRITE_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_OVERWRITE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRFO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRFO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/brfo_pkg.sv]
// Shared types and constants of the byte ring FIFO.
`timescale 1ns / 1ps
package brfo_pkg;

  localparam int unsigned CapW        = 11;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CntW        = 7;
  localparam int unsigned FuncW       = 2;
  localparam int unsigned CapResetMax = 1024;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERWRITE = 2'd1,
    STAT_EMPTY     = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ptr_cmd_t;

  typedef struct packed {
    logic [CapW-1:0] fill;
    logic            empty;
    logic            full;
  } level_t;

endpackage

[rtl/core/brfo_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module brfo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/brfo_ptr.sv]
// Pointer, full flag and capacity register of the byte ring FIFO.
`timescale 1ns / 1ps
module brfo_ptr import brfo_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CapW-1:0]          cfg_wdata_i,
  input  ptr_cmd_t                 cmd_i,
  output logic [$clog2(DEPTH)-1:0] wr_ptr_o,
  output logic [$clog2(DEPTH)-1:0] rd_ptr_o,
  output logic [$clog2(DEPTH)-1:0] rd_ptr_nx_o,
  output level_t                   lvl_cur_o,
  output level_t                   lvl_nxt_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = ((PW > CapW) ? PW : CapW) + 1;
  localparam logic [CapW-1:0] CapRst = CapW'((DEPTH < CapResetMax) ? DEPTH : CapResetMax);

  logic [CapW-1:0] cap_q, cap_d;
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic            full_q, full_d;
  logic [PW-1:0]   wr_nx, rd_nx;

  // Step a pointer, wrapping at the capacity in use.
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p, input logic [CapW-1:0] c);
    logic [LW-1:0] inc;
    inc = LW'(p) + LW'(1);
    return (inc >= LW'(c)) ? '0 : inc[PW-1:0];
  endfunction

  function automatic level_t level_of(input logic [PW-1:0] w, input logic [PW-1:0] r,
                                      input logic f, input logic [CapW-1:0] c);
    logic [LW-1:0] v;
    level_t        l;
    if (f) begin
      v = LW'(c);
    end else if (w >= r) begin
      v = LW'(w) - LW'(r);
    end else begin
      v = LW'(c) + LW'(w) - LW'(r);
    end
    l.fill  = v[CapW-1:0];
    l.empty = (v == '0);
    l.full  = f;
    return l;
  endfunction

  always_comb begin
    wr_nx  = ptr_inc(wr_q, cap_q);
    rd_nx  = ptr_inc(rd_q, cap_q);
    cap_d  = cap_q;
    wr_d   = wr_q;
    rd_d   = rd_q;
    full_d = full_q;
    if (cfg_we_i) begin
      // Clamp the capacity into range and empty the store.
      if (cfg_wdata_i == '0) begin
        cap_d = CapW'(1);
      end else if (32'(cfg_wdata_i) > 32'(DEPTH)) begin
        cap_d = CapW'(DEPTH);
      end else begin
        cap_d = cfg_wdata_i;
      end
      wr_d   = '0;
      rd_d   = '0;
      full_d = 1'b0;
    end else if (cmd_i.flush) begin
      wr_d   = '0;
      rd_d   = '0;
      full_d = 1'b0;
    end else if (cmd_i.push) begin
      wr_d = wr_nx;
      if (full_q) begin
        rd_d = rd_nx;
      end else begin
        full_d = (wr_nx == rd_q);
      end
    end else if (cmd_i.pop) begin
      rd_d   = rd_nx;
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapRst;
      wr_q   <= '0;
      rd_q   <= '0;
      full_q <= 1'b0;
    end else begin
      cap_q  <= cap_d;
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      full_q <= full_d;
    end
  end

  assign wr_ptr_o    = wr_q;
  assign rd_ptr_o    = rd_q;
  assign rd_ptr_nx_o = rd_nx;
  assign lvl_cur_o   = level_of(wr_q, rd_q, full_q, cap_q);
  assign lvl_nxt_o   = level_of(wr_d, rd_d, full_d, cap_d);

endmodule

[rtl/core/byte_ring_fifo_overwrite_top.sv]
// Top level of the byte ring FIFO that overwrites its oldest byte when full.
//
// Input channel (in_valid_i / in_ready_o) carries one operation per transfer:
// push a byte, pop a burst of up to pop_count_i bytes (clamped to 1 ..
// MAX_BURST), or flush. Output channel (out_valid_o / out_ready_i) carries one
// result per transfer, each with the fill level and empty / full flags after its
// operation; last_o marks the final result of an operation.
// Order: a push, flush or empty pop gives its single result in the cycle after
// its transfer. A burst pop gives its first byte through the registered RAM read
// and the output register, then one byte per cycle while the receiver is ready.
// Throughput: one push per cycle while the receiver does not stall; the block
// takes no new operation until a burst is finished.
// The user writes the capacity register (cfg_we_i / cfg_wdata_i) only while
// idle; the block does not enforce it. Any write empties the FIFO. Reset empties
// the FIFO, sets the capacity to min(DEPTH, 1024); RAM contents are not cleared.
// When the receiver stalls, the result is held in the output register and the
// block takes no new operation and pops no further byte until it is taken.
`timescale 1ns / 1ps
module byte_ring_fifo_overwrite_top import brfo_pkg::*; #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CapW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FuncW-1:0]  func_i,
  input  logic [ByteW-1:0]  push_byte_i,
  input  logic [CntW-1:0]   pop_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [ByteW-1:0]  pop_byte_o,
  output logic [CapW-1:0]   fill_level_o,
  output logic              is_empty_o,
  output logic              is_full_o,
  output logic              last_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d, k_q, k_d;
  ptr_cmd_t         cmd;
  logic [PW-1:0]    wr_ptr, rd_ptr, rd_nx, raddr;
  level_t           lvl_cur, lvl_nxt;
  logic [ByteW-1:0] rdata;
  logic             mem_we, accept, out_free, load, fin;
  status_e          res_status;
  logic [ByteW-1:0] res_byte;
  logic             res_last;
  logic [CntW-1:0]  cnt_clamped;

  // Output register: valid, status, byte, levels and last flag.
  logic             out_valid_q;
  status_e          status_q;
  logic [ByteW-1:0] pop_byte_q;
  level_t           lvl_q;
  logic             last_q;

  brfo_ptr #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .cmd_i      (cmd),
    .wr_ptr_o   (wr_ptr),
    .rd_ptr_o   (rd_ptr),
    .rd_ptr_nx_o(rd_nx),
    .lvl_cur_o  (lvl_cur),
    .lvl_nxt_o  (lvl_nxt)
  );

  // Read the entry that the next pop will take: the advanced pointer while popping,
  // else the current one, so a burst runs at one byte a cycle unless stalled.
  assign raddr = cmd.pop ? rd_nx : rd_ptr;

  brfo_ram #(
    .Width(ByteW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(wr_ptr),
    .wdata_i(push_byte_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Clamp the requested burst length to 1 .. MAX_BURST.
  always_comb begin
    if (pop_count_i == '0) begin
      cnt_clamped = CntW'(1);
    end else if (32'(pop_count_i) > 32'(MAX_BURST)) begin
      cnt_clamped = CntW'(MAX_BURST);
    end else begin
      cnt_clamped = pop_count_i;
    end
  end

  assign fin = ((k_q + CntW'(1)) == cnt_q) || lvl_nxt.empty;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    cmd        = '0;
    mem_we     = 1'b0;
    load       = 1'b0;
    res_status = STAT_OK;
    res_byte   = '0;
    res_last   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_PUSH: begin
              cmd.push   = 1'b1;
              mem_we     = 1'b1;
              load       = 1'b1;
              res_status = lvl_cur.full ? STAT_OVERWRITE : STAT_OK;
            end
            FUNC_POP: begin
              if (lvl_cur.empty) begin
                load       = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                state_d = ST_POP;
                cnt_d   = cnt_clamped;
                k_d     = '0;
              end
            end
            FUNC_FLUSH: begin
              cmd.flush = 1'b1;
              load      = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        // Pop one byte per cycle while the output register can take it.
        if (out_free) begin
          cmd.pop  = 1'b1;
          load     = 1'b1;
          res_byte = rdata;
          res_last = fin;
          k_d      = k_q + CntW'(1);
          if (fin) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next load.
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q   <= res_status;
      pop_byte_q <= res_byte;
      lvl_q      <= lvl_nxt;
      last_q     <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign pop_byte_o   = pop_byte_q;
  assign fill_level_o = lvl_q.fill;
  assign is_empty_o   = lvl_q.empty;
  assign is_full_o    = lvl_q.full;
  assign last_o       = last_q;

endmodule

[rtl/core/brfo_checker.sv]
// Port-level checker of the byte ring FIFO and its bind to the top level.
`timescale 1ns / 1ps
`include "byte_ring_fifo_overwrite_top_defines.svh"
module brfo_checker import brfo_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [ByteW-1:0]  pop_byte_o,
  input logic [CapW-1:0]   fill_level_o,
  input logic              is_empty_o,
  input logic              is_full_o,
  input logic              last_o
);

  `BRFO_ASSERT_IMP(a_empty_matches_fill, out_valid_o, is_empty_o == (fill_level_o == '0), "is_empty_o disagrees with fill_level_o")
  `BRFO_ASSERT_IMP(a_not_empty_and_full, out_valid_o, !(is_empty_o && is_full_o), "is_empty_o and is_full_o both set")
  `BRFO_ASSERT_IMP(a_empty_pop_result, out_valid_o && (status_o == STAT_EMPTY), last_o && is_empty_o && (pop_byte_o == '0), "empty pop result malformed")
  `BRFO_ASSERT_IMP(a_overwrite_full, out_valid_o && (status_o == STAT_OVERWRITE), is_full_o && last_o && (pop_byte_o == '0), "overwrite result not full")
  `BRFO_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(pop_byte_o) && $stable(last_o), "stalled result changed")

endmodule

bind byte_ring_fifo_overwrite_top brfo_checker u_brfo_checker (.*);
